FILE: hdl/mpm_pkg.sv
// Shared types and constants for the multi-pattern matcher.
// Used by the matcher, its engine and the port checks; depends on nothing.
package mpm_pkg;

    localparam int DEF_MAX_NODES    = 256;
    localparam int DEF_MAX_PATTERNS = 16;
    localparam int DEF_SYMBOL_BITS  = 8;
    localparam int MAX_RESULTS      = 16;

    localparam logic [1:0] CMD_PAT_SYM = 2'd0;
    localparam logic [1:0] CMD_PAT_END = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] ST_MATCH = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] symbol;
    } t_in;

    typedef struct packed {
        logic [31:0] match_start;
        logic [4:0]  pattern_id;
        logic [1:0]  status;
        logic        last;
    } t_out;

endpackage

FILE: hdl/multi_pattern_matcher.sv
// Aho-Corasick multi-pattern matcher: engine plus the output register.
// A text symbol steps the automaton, following failure links as needed, and reports
// the patterns that end on the suffix chain, held while the output stalls. The first
// one also builds the failure links breadth-first. Reset and the clear command sweep
// all MAX_NODES << SYMBOL_BITS entries of the child table, input stalled.
module multi_pattern_matcher #(
    parameter int MAX_NODES    = mpm_pkg::DEF_MAX_NODES,
    parameter int MAX_PATTERNS = mpm_pkg::DEF_MAX_PATTERNS,
    parameter int SYMBOL_BITS  = mpm_pkg::DEF_SYMBOL_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mpm_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output mpm_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import mpm_pkg::*;

    logic slot_free;
    logic push;
    t_out res;
    logic r_out_valid;
    t_out r_out_data;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    mpm_engine #(
        .MAX_NODES(MAX_NODES), .MAX_PATTERNS(MAX_PATTERNS), .SYMBOL_BITS(SYMBOL_BITS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_in_data(i_in_data), .o_in_stall(o_in_stall), .i_slot_free(slot_free),
        .o_push(push), .o_res(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            r_out_data <= res;
        end
    end
endmodule

FILE: hdl/mpm_ram.sv
// Simple synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing.
module mpm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: hdl/mpm_engine.sv
// Sequencer of the matcher: trie insert, breadth-first link build, automaton
// step and suffix-chain reporting over the trie memories.
// Depends on mpm_pkg and mpm_ram.
module mpm_engine #(
    parameter int MAX_NODES    = mpm_pkg::DEF_MAX_NODES,
    parameter int MAX_PATTERNS = mpm_pkg::DEF_MAX_PATTERNS,
    parameter int SYMBOL_BITS  = mpm_pkg::DEF_SYMBOL_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mpm_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    input  logic          i_slot_free,
    output logic          o_push,
    output mpm_pkg::t_out o_res
);
    import mpm_pkg::*;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int C_DEPTH = MAX_NODES << SYMBOL_BITS;
    localparam int ADDR_W  = NODE_W + SYMBOL_BITS;
    localparam int PID_W   = $clog2(MAX_PATTERNS + 1);
    localparam int PIDX_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_INS, S_B_POP, S_B_V, S_B_FV, S_B_CRD,
        S_B_CCHK, S_W_RD, S_W_CHK, S_W_FRD, S_R_CHK, S_R_DAT, S_R_PUSH, S_R_FIN
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0]      r_sweep, n_sweep;
    logic [1:0]             r_cmd, n_cmd;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [NODE_W:0]        r_node_count, n_node_count;
    logic [PID_W-1:0]       r_pc, n_pc;
    logic [NODE_W-1:0]      r_cursor, n_cursor;
    logic [NODE_W-1:0]      r_depth, n_depth;
    logic [NODE_W-1:0]      r_current, n_current;
    logic [31:0]            r_tp, n_tp;
    logic                   r_started, n_started;
    logic [NODE_W-1:0]      r_plen [MAX_PATTERNS];
    logic [NODE_W:0]        r_head, n_head, r_tail, n_tail;
    logic [NODE_W-1:0]      r_v, n_v, r_fv, n_fv, r_c, n_c;
    logic [SYMBOL_BITS-1:0] r_s, n_s, r_wsym, n_wsym;
    logic [NODE_W-1:0]      r_wnode, n_wnode, r_u, n_u;
    logic                   r_in_build, n_in_build;
    logic [RES_W-1:0]       r_nres, n_nres;
    t_out                   r_pend, n_pend, r_new, n_new;
    logic                   r_pend_v, n_pend_v;

    logic                   plen_we;

    logic                   c_we, c_re;
    logic [ADDR_W-1:0]      c_waddr, c_raddr;
    logic [NODE_W-1:0]      c_wdata, c_rdata;
    logic                   f_we, f_re;
    logic [NODE_W-1:0]      f_waddr, f_raddr, f_wdata, f_rdata;
    logic                   p_we, p_re;
    logic [NODE_W-1:0]      p_waddr, p_raddr;
    logic [PID_W-1:0]       p_wdata, p_rdata;
    logic                   q_we, q_re;
    logic [NODE_W-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;

    logic [31:0]            match_start;
    logic [PIDX_W-1:0]      plen_idx;

    mpm_ram #(.DEPTH(C_DEPTH), .WIDTH(NODE_W)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata));
    mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_re(f_re), .i_raddr(f_raddr), .o_rdata(f_rdata));
    mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(PID_W)) u_pat (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_re(p_re), .i_raddr(p_raddr), .o_rdata(p_rdata));
    mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rdata));

    assign o_in_stall  = (r_state != S_IDLE);
    assign plen_idx    = PIDX_W'(p_rdata - PID_W'(1));
    assign match_start = r_tp - {{(32 - NODE_W){1'b0}}, r_plen[plen_idx]} + 32'd1;

    always_comb begin
        n_state = r_state;       n_sweep = r_sweep;     n_cmd = r_cmd;
        n_sym = r_sym;           n_node_count = r_node_count;
        n_pc = r_pc;             n_cursor = r_cursor;   n_depth = r_depth;
        n_current = r_current;   n_tp = r_tp;           n_started = r_started;
        n_head = r_head;         n_tail = r_tail;       n_v = r_v;
        n_fv = r_fv;             n_c = r_c;             n_s = r_s;
        n_wsym = r_wsym;         n_wnode = r_wnode;     n_u = r_u;
        n_in_build = r_in_build; n_nres = r_nres;       n_pend = r_pend;
        n_new = r_new;           n_pend_v = r_pend_v;
        plen_we = 1'b0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
        o_push = 1'b0;
        o_res  = r_pend;

        case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_sweep;
                if ({1'b0, r_sweep} < (ADDR_W + 1)'(MAX_NODES)) begin
                    f_we    = 1'b1;
                    f_waddr = r_sweep[NODE_W-1:0];
                    p_we    = 1'b1;
                    p_waddr = r_sweep[NODE_W-1:0];
                end
                if (r_sweep == ADDR_W'(C_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_sym   = i_in_data.symbol[SYMBOL_BITS-1:0];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (r_cmd)
                    CMD_PAT_SYM: begin
                        if (r_started) begin
                            n_pend   = '{32'd0, 5'd0, ST_ORDER, 1'b0};
                            n_pend_v = 1'b1;
                            n_state  = S_R_FIN;
                        end else begin
                            c_re    = 1'b1;
                            c_raddr = {r_cursor, r_sym};
                            n_state = S_INS;
                        end
                    end
                    CMD_PAT_END: begin
                        if (r_started) begin
                            n_pend   = '{32'd0, 5'd0, ST_ORDER, 1'b0};
                            n_pend_v = 1'b1;
                            n_state  = S_R_FIN;
                        end else begin
                            if (r_pc >= PID_W'(MAX_PATTERNS)) begin
                                n_pend   = '{32'd0, 5'd0, ST_ORDER, 1'b0};
                                n_pend_v = 1'b1;
                                n_state  = S_R_FIN;
                            end else begin
                                plen_we = 1'b1;
                                p_we    = 1'b1;
                                p_waddr = r_cursor;
                                p_wdata = r_pc + PID_W'(1);
                                n_pc    = r_pc + PID_W'(1);
                                n_state = S_IDLE;
                            end
                            n_cursor = '0;
                            n_depth  = '0;
                        end
                    end
                    CMD_TEXT: begin
                        n_tp = r_tp + 32'd1;
                        if (!r_started) begin
                            // Seed the breadth-first queue with the root.
                            q_we    = 1'b1;
                            q_waddr = '0;
                            n_head  = '0;
                            n_tail  = (NODE_W + 1)'(1);
                            n_state = S_B_POP;
                        end else begin
                            n_wnode    = r_current;
                            n_wsym     = r_sym;
                            n_in_build = 1'b0;
                            n_state    = S_W_RD;
                        end
                    end
                    default: begin
                        n_node_count = (NODE_W + 1)'(1);
                        n_pc      = '0;
                        n_cursor  = '0;
                        n_depth   = '0;
                        n_current = '0;
                        n_tp      = '0;
                        n_started = 1'b0;
                        n_sweep   = '0;
                        n_state   = S_CLEAR;
                    end
                endcase
            end
            S_INS: begin
                n_state = S_IDLE;
                if (c_rdata != '0) begin
                    n_cursor = c_rdata;
                    n_depth  = r_depth + NODE_W'(1);
                end else if (r_node_count >= (NODE_W + 1)'(MAX_NODES)) begin
                    n_pend   = '{32'd0, 5'd0, ST_FULL, 1'b0};
                    n_pend_v = 1'b1;
                    n_state  = S_R_FIN;
                end else begin
                    c_we         = 1'b1;
                    c_waddr      = {r_cursor, r_sym};
                    c_wdata      = r_node_count[NODE_W-1:0];
                    n_cursor     = r_node_count[NODE_W-1:0];
                    n_node_count = r_node_count + (NODE_W + 1)'(1);
                    n_depth      = r_depth + NODE_W'(1);
                end
            end
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_started  = 1'b1;
                    n_wnode    = r_current;
                    n_wsym     = r_sym;
                    n_in_build = 1'b0;
                    n_state    = S_W_RD;
                end else begin
                    q_re    = 1'b1;
                    q_raddr = r_head[NODE_W-1:0];
                    n_state = S_B_V;
                end
            end
            S_B_V: begin
                n_v     = q_rdata;
                n_head  = r_head + (NODE_W + 1)'(1);
                n_s     = '0;
                f_re    = 1'b1;
                f_raddr = q_rdata;
                n_state = S_B_FV;
            end
            S_B_FV: begin
                n_fv    = f_rdata;
                n_state = S_B_CRD;
            end
            S_B_CRD: begin
                c_re    = 1'b1;
                c_raddr = {r_v, r_s};
                n_state = S_B_CCHK;
            end
            S_B_CCHK: begin
                if (c_rdata != '0 && r_v != '0) begin
                    // Deeper child: its link is goto(fail(parent), s).
                    n_c        = c_rdata;
                    n_wnode    = r_fv;
                    n_wsym     = r_s;
                    n_in_build = 1'b1;
                    n_state    = S_W_RD;
                end else begin
                    if (c_rdata != '0) begin
                        f_we    = 1'b1;
                        f_waddr = c_rdata;
                        q_we    = 1'b1;
                        q_waddr = r_tail[NODE_W-1:0];
                        q_wdata = c_rdata;
                        n_tail  = r_tail + (NODE_W + 1)'(1);
                    end
                    if (r_s == '1) begin
                        n_state = S_B_POP;
                    end else begin
                        n_s     = r_s + SYMBOL_BITS'(1);
                        n_state = S_B_CRD;
                    end
                end
            end
            S_W_RD: begin
                c_re    = 1'b1;
                c_raddr = {r_wnode, r_wsym};
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                if (r_wnode != '0 && c_rdata == '0) begin
                    f_re    = 1'b1;
                    f_raddr = r_wnode;
                    n_state = S_W_FRD;
                end else if (r_in_build) begin
                    f_we    = 1'b1;
                    f_waddr = r_c;
                    f_wdata = c_rdata;
                    q_we    = 1'b1;
                    q_waddr = r_tail[NODE_W-1:0];
                    q_wdata = r_c;
                    n_tail  = r_tail + (NODE_W + 1)'(1);
                    if (r_s == '1) begin
                        n_state = S_B_POP;
                    end else begin
                        n_s     = r_s + SYMBOL_BITS'(1);
                        n_state = S_B_CRD;
                    end
                end else begin
                    n_current = c_rdata;
                    n_u       = c_rdata;
                    n_nres    = '0;
                    n_state   = S_R_CHK;
                end
            end
            S_W_FRD: begin
                n_wnode = f_rdata;
                n_state = S_W_RD;
            end
            S_R_CHK: begin
                if (r_u == '0 || r_nres == RES_W'(MAX_RESULTS)) begin
                    n_state = r_pend_v ? S_R_FIN : S_IDLE;
                end else begin
                    p_re    = 1'b1;
                    p_raddr = r_u;
                    f_re    = 1'b1;
                    f_raddr = r_u;
                    n_state = S_R_DAT;
                end
            end
            S_R_DAT: begin
                n_u     = f_rdata;
                n_state = S_R_CHK;
                if (p_rdata != '0) begin
                    n_new = '{match_start, 5'(p_rdata), ST_MATCH, 1'b0};
                    if (r_pend_v) begin
                        n_state = S_R_PUSH;
                    end else begin
                        n_pend   = n_new;
                        n_pend_v = 1'b1;
                        n_nres   = r_nres + RES_W'(1);
                    end
                end
            end
            S_R_PUSH: begin
                // The held match is not the last one: a newer one follows it.
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_pend  = r_new;
                    n_nres  = r_nres + RES_W'(1);
                    n_state = S_R_CHK;
                end
            end
            S_R_FIN: begin
                o_res.last = 1'b1;
                if (i_slot_free) begin
                    o_push   = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_sweep      <= '0;
            r_node_count <= (NODE_W + 1)'(1);
            r_pc         <= '0;
            r_cursor     <= '0;
            r_depth      <= '0;
            r_current    <= '0;
            r_tp         <= '0;
            r_started    <= 1'b0;
            r_pend_v     <= 1'b0;
            r_in_build   <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_nres       <= '0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_node_count <= n_node_count;
            r_pc         <= n_pc;
            r_cursor     <= n_cursor;
            r_depth      <= n_depth;
            r_current    <= n_current;
            r_tp         <= n_tp;
            r_started    <= n_started;
            r_pend_v     <= n_pend_v;
            r_in_build   <= n_in_build;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_nres       <= n_nres;
        end
        r_cmd   <= n_cmd;
        r_sym   <= n_sym;
        r_v     <= n_v;
        r_fv    <= n_fv;
        r_c     <= n_c;
        r_s     <= n_s;
        r_wsym  <= n_wsym;
        r_wnode <= n_wnode;
        r_u     <= n_u;
        r_pend  <= n_pend;
        r_new   <= n_new;
        if (plen_we) begin
            r_plen[PIDX_W'(r_pc)] <= r_depth;
        end
    end
endmodule

FILE: hdl/mpm_checker.sv
// Port-level checks for the matcher and the bind that attaches them.
// Depends on mpm_pkg and multi_pattern_matcher.
module mpm_port_checks (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input mpm_pkg::t_out o_out_data,
    input logic          i_out_stall
);
    import mpm_pkg::*;

    // A result waiting under stall keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_MATCH |->
            o_out_data.last && o_out_data.pattern_id == 5'd0 &&
            o_out_data.match_start == 32'd0)
        else $error("malformed error result");

    a_match_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_MATCH |-> o_out_data.pattern_id != 5'd0)
        else $error("match without pattern number");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result visible after reset");
endmodule

bind multi_pattern_matcher mpm_port_checks u_mpm_port_checks (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .o_out_data(o_out_data), .i_out_stall(i_out_stall));
